// File: sv/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg: shared definitions for the back-face cull core
// Default widths, pipeline stage map, register indexes and control types.
// ----------------------------------------------------------------------------
package tbc_pkg;

  // Default coordinate width (signed Q16.16)
  localparam int COORD_BITS_DEF = 32;

  // Width of the configuration write data
  localparam int REG_BITS = 32;

  // Width of one unsigned chunk in the multiplier partial products
  localparam int MUL_CHUNK = 32;

  // Register stages inside one multiplier
  localparam int MUL_STG = 4;

  // Pipeline stage map
  localparam int ST_DIFF  = 0;                  // edge and view vectors
  localparam int ST_CROSS = ST_DIFF + 1;        // cross-product multipliers
  localparam int ST_NORM  = ST_CROSS + MUL_STG; // normal components
  localparam int ST_DOT   = ST_NORM + 1;        // dot-product multipliers
  localparam int ST_SUM   = ST_DOT + MUL_STG;   // dot-product sum
  localparam int ST_OUT   = ST_SUM + 1;         // result register
  localparam int N_STG    = ST_OUT + 1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CAM_X = 2'd0,
    CFG_CAM_Y = 2'd1,
    CFG_CAM_Z = 2'd2
  } tbc_cfg_idx_t;

  // Per-item control that travels beside the arithmetic
  typedef struct packed {
    logic test;     // run the dot-product test
    logic flag_bf;  // already-backfacing flag, used on pass-through
    logic last;     // last polygon of the list
  } tbc_item_t;

  // Stage enables and valid bits from the pipeline controller
  typedef struct packed {
    logic [N_STG-1:0] en;
    logic [N_STG-1:0] vld;
  } tbc_pipe_t;

endpackage

// File: sv/tbc_in_if.sv
// ----------------------------------------------------------------------------
// tbc_in_if: triangle input channel
// Valid/ready channel carrying three vertices and the polygon flags.
// ----------------------------------------------------------------------------
interface tbc_in_if #(
  parameter int COORD_BITS = tbc_pkg::COORD_BITS_DEF
) ();

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] v0_x;
  logic signed [COORD_BITS-1:0] v0_y;
  logic signed [COORD_BITS-1:0] v0_z;
  logic signed [COORD_BITS-1:0] v1_x;
  logic signed [COORD_BITS-1:0] v1_y;
  logic signed [COORD_BITS-1:0] v1_z;
  logic signed [COORD_BITS-1:0] v2_x;
  logic signed [COORD_BITS-1:0] v2_y;
  logic signed [COORD_BITS-1:0] v2_z;
  logic [3:0]                   poly_flags;
  logic                         last_poly;

  modport source (
    output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
           poly_flags, last_poly,
    input  ready
  );

  modport sink (
    input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
           poly_flags, last_poly,
    output ready
  );

endinterface

// File: sv/tbc_out_if.sv
// ----------------------------------------------------------------------------
// tbc_out_if: cull result channel
// Valid/ready channel carrying the backface verdict of one polygon.
// ----------------------------------------------------------------------------
interface tbc_out_if ();

  logic valid;
  logic ready;
  logic backface;
  logic tested;
  logic last_out;

  modport source (
    output valid, backface, tested, last_out,
    input  ready
  );

  modport sink (
    input  valid, backface, tested, last_out,
    output ready
  );

endinterface

// File: sv/triangle_backface_cull_core.sv
// ----------------------------------------------------------------------------
// triangle_backface_cull_core: view-vector back-face cull stage
// Forms n = (v1-v0) x (v2-v0) and w = cam - v0 exactly and marks the
// polygon backfacing when n . w <= 0; skipped polygons pass through.
// ----------------------------------------------------------------------------
//
//  Port     | Dir | Transfer when      | Carries
//  ---------+-----+--------------------+-----------------------------------
//  in_tri   | in  | valid && ready     | v0..v2 xyz, poly_flags, last_poly
//  out_res  | out | valid && ready     | backface, tested, last_out
//  cfg_*    | in  | cfg_we             | cam_x / cam_y / cam_z by cfg_idx
//
//  One triangle per cycle unless a stalled output has backed the pipeline
//  up; a result passes the difference stage, 4-stage cross multipliers,
//  normal stage, 4-stage dot multipliers, sum stage and the result register.
//  Each stage holds only while it is full and the stage after it holds, so
//  a stalled output fills the bubbles before in_tri.ready drops.
//  rst_n is synchronous: it empties the pipeline and clears the camera.
//
module triangle_backface_cull_core #(
  parameter int COORD_BITS = tbc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tbc_in_if.sink                        in_tri,
  tbc_out_if.source                     out_res,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [tbc_pkg::REG_BITS-1:0]  cfg_wdata
);

  localparam int DW = COORD_BITS + 1; // vertex difference
  localparam int CW = 2 * DW;         // cross partial product
  localparam int NW = CW + 1;         // normal component
  localparam int TW = NW + DW;        // dot-product term
  localparam int SW = TW + 2;         // dot-product sum

  localparam int ST_DIFF  = tbc_pkg::ST_DIFF;
  localparam int ST_CROSS = tbc_pkg::ST_CROSS;
  localparam int ST_NORM  = tbc_pkg::ST_NORM;
  localparam int ST_DOT   = tbc_pkg::ST_DOT;
  localparam int ST_SUM   = tbc_pkg::ST_SUM;
  localparam int ST_OUT   = tbc_pkg::ST_OUT;
  localparam int MS       = tbc_pkg::MUL_STG;

  tbc_pkg::tbc_pipe_t pipe;

  logic signed [COORD_BITS-1:0] cam_x_r;
  logic signed [COORD_BITS-1:0] cam_y_r;
  logic signed [COORD_BITS-1:0] cam_z_r;

  // index 0/1/2 = x/y/z
  logic signed [DW-1:0] u_r [3];
  logic signed [DW-1:0] v_r [3];
  logic signed [DW-1:0] w_r [ST_NORM+1][3];
  tbc_pkg::tbc_item_t   item_r [ST_SUM+1];
  logic signed [CW-1:0] pa [3];
  logic signed [CW-1:0] pb [3];
  logic signed [NW-1:0] n_r [3];
  logic signed [TW-1:0] t [3];
  logic signed [SW-1:0] sum_r;
  logic                 backface_r;
  logic                 tested_r;
  logic                 last_r;
  logic                 in_acc;
  logic                 out_acc;

  // Pipeline control
  tbc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tri.valid),
    .out_ready (out_res.ready),
    .pipe      (pipe)
  );

  assign in_tri.ready = pipe.en[ST_DIFF] && rst_n;
  assign in_acc       = in_tri.valid && in_tri.ready;
  assign out_acc      = out_res.valid && out_res.ready;

  // Camera registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tbc_pkg::CFG_CAM_X: cam_x_r <= COORD_BITS'(cfg_wdata);
        tbc_pkg::CFG_CAM_Y: cam_y_r <= COORD_BITS'(cfg_wdata);
        tbc_pkg::CFG_CAM_Z: cam_z_r <= COORD_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Difference stage: edge vectors, view vector and item control
  always_ff @(posedge clk) begin
    if (pipe.en[ST_DIFF]) begin
      u_r[0] <= DW'(in_tri.v1_x) - DW'(in_tri.v0_x);
      u_r[1] <= DW'(in_tri.v1_y) - DW'(in_tri.v0_y);
      u_r[2] <= DW'(in_tri.v1_z) - DW'(in_tri.v0_z);
      v_r[0] <= DW'(in_tri.v2_x) - DW'(in_tri.v0_x);
      v_r[1] <= DW'(in_tri.v2_y) - DW'(in_tri.v0_y);
      v_r[2] <= DW'(in_tri.v2_z) - DW'(in_tri.v0_z);
      w_r[ST_DIFF][0] <= DW'(cam_x_r) - DW'(in_tri.v0_x);
      w_r[ST_DIFF][1] <= DW'(cam_y_r) - DW'(in_tri.v0_y);
      w_r[ST_DIFF][2] <= DW'(cam_z_r) - DW'(in_tri.v0_z);
      // test only active polygons with no other flag set
      item_r[ST_DIFF].test    <= (in_tri.poly_flags == 4'b0001);
      item_r[ST_DIFF].flag_bf <= in_tri.poly_flags[3];
      item_r[ST_DIFF].last    <= in_tri.last_poly;
    end

    // Carry the view vector up to the dot multipliers
    for (int k = ST_DIFF + 1; k <= ST_NORM; k++) begin
      if (pipe.en[k]) begin
        w_r[k] <= w_r[k-1];
      end
    end

    // Carry item control up to the sum stage
    for (int k = ST_DIFF + 1; k <= ST_SUM; k++) begin
      if (pipe.en[k]) begin
        item_r[k] <= item_r[k-1];
      end
    end
  end

  // Cross product and dot product lanes
  for (genvar c = 0; c < 3; c++) begin : g_lane
    localparam int J = (c + 1) % 3;
    localparam int K = (c + 2) % 3;

    tbc_mul #(.AW(DW), .BW(DW)) u_mul_a (
      .clk (clk),
      .en  (pipe.en[ST_CROSS +: MS]),
      .a   (u_r[J]),
      .b   (v_r[K]),
      .p   (pa[c])
    );

    tbc_mul #(.AW(DW), .BW(DW)) u_mul_b (
      .clk (clk),
      .en  (pipe.en[ST_CROSS +: MS]),
      .a   (u_r[K]),
      .b   (v_r[J]),
      .p   (pb[c])
    );

    // Normal component
    always_ff @(posedge clk) begin
      if (pipe.en[ST_NORM]) begin
        n_r[c] <= NW'(pa[c]) - NW'(pb[c]);
      end
    end

    tbc_mul #(.AW(NW), .BW(DW)) u_mul_dot (
      .clk (clk),
      .en  (pipe.en[ST_DOT +: MS]),
      .a   (n_r[c]),
      .b   (w_r[ST_NORM][c]),
      .p   (t[c])
    );
  end

  // Sum the three dot-product terms
  always_ff @(posedge clk) begin
    if (pipe.en[ST_SUM]) begin
      sum_r <= SW'(t[0]) + SW'(t[1]) + SW'(t[2]);
    end
  end

  // Result register: verdict on tested polygons, flag on pass-through
  always_ff @(posedge clk) begin
    if (pipe.en[ST_OUT]) begin
      backface_r <= item_r[ST_SUM].test ? (sum_r[SW-1] || (sum_r == '0))
                                        : item_r[ST_SUM].flag_bf;
      tested_r   <= item_r[ST_SUM].test;
      last_r     <= item_r[ST_SUM].last;
    end
  end

  assign out_res.valid    = pipe.vld[ST_OUT];
  assign out_res.backface = backface_r;
  assign out_res.tested   = tested_r;
  assign out_res.last_out = last_r;

  // Items in flight change only by transfers in and out
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(pipe.vld) ==
      $countones($past(pipe.vld)) + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("pipeline occupancy does not match transfers");

  // Input may only be taken with room in the pipeline
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tri.ready |-> (pipe.vld != '1) || out_res.ready)
    else $error("input taken into a full pipeline");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (pipe.vld == '0))
    else $error("pipeline not empty after reset");

endmodule

// File: sv/tbc_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// tbc_pipe_ctrl: valid bits and stage enables of the cull pipeline
// A stage loads when it is empty or when the stage after it loads, so
// bubbles close up while the output is stalled.
// ----------------------------------------------------------------------------
module tbc_pipe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_ready,
  output tbc_pkg::tbc_pipe_t pipe
);

  localparam int N = tbc_pkg::N_STG;

  logic [N-1:0] vld_r;
  logic [N-1:0] vld_nxt;
  logic [N-1:0] en;

  // Enable chain, from the output back to the input
  always_comb begin
    en[N-1] = !vld_r[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  // Advance valid bits with the data
  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < N; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign pipe.en  = en;
  assign pipe.vld = vld_r;

endmodule

// File: sv/tbc_mul.sv
// ----------------------------------------------------------------------------
// tbc_mul: pipelined exact signed multiplier
// Sign-magnitude form: magnitudes, chunked partial products, summed
// magnitude, signed result. Four register stages, one per enable bit.
// ----------------------------------------------------------------------------
module tbc_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                              clk,
  input  logic [tbc_pkg::MUL_STG-1:0]       en,
  input  logic signed [AW-1:0]              a,
  input  logic signed [BW-1:0]              b,
  output logic signed [AW+BW-1:0]           p
);

  localparam int CH = tbc_pkg::MUL_CHUNK;
  localparam int NA = (AW + CH - 1) / CH;
  localparam int NB = (BW + CH - 1) / CH;
  localparam int PW = AW + BW;

  logic [AW-1:0]        mag_a_r;
  logic [BW-1:0]        mag_b_r;
  logic                 neg1_r;
  logic                 neg2_r;
  logic                 neg3_r;
  logic [NA*CH-1:0]     a_pad;
  logic [NB*CH-1:0]     b_pad;
  logic [2*CH-1:0]      pp_nxt [NA][NB];
  logic [2*CH-1:0]      pp_r   [NA][NB];
  logic [PW-1:0]        mag_nxt;
  logic [PW-1:0]        mag_r;
  logic signed [PW-1:0] p_r;

  // Stage 1: take magnitudes and the result sign
  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag_a_r <= a[AW-1] ? AW'(~a + AW'(1)) : AW'(a);
      mag_b_r <= b[BW-1] ? BW'(~b + BW'(1)) : BW'(b);
      neg1_r  <= a[AW-1] ^ b[BW-1];
    end
  end

  // Stage 2: chunk by chunk partial products
  always_comb begin
    a_pad = (NA*CH)'(mag_a_r);
    b_pad = (NB*CH)'(mag_b_r);
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_nxt[i][j] = a_pad[i*CH +: CH] * b_pad[j*CH +: CH];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pp_r   <= pp_nxt;
      neg2_r <= neg1_r;
    end
  end

  // Stage 3: align and add the partial products
  always_comb begin
    mag_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        mag_nxt = mag_nxt + (PW'(pp_r[i][j]) << (CH * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mag_r  <= mag_nxt;
      neg3_r <= neg2_r;
    end
  end

  // Stage 4: restore the sign
  always_ff @(posedge clk) begin
    if (en[3]) begin
      p_r <= neg3_r ? (~mag_r + PW'(1)) : mag_r;
    end
  end

  assign p = p_r;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the triangle back-face cull core
// Streams triangles through the valid/ready channels and predicts each
// verdict with exact wide arithmetic against the camera registers. Results
// are compared field by field in transfer order. Directed flag and geometry
// cases come first, then camera sweeps with random sender gaps, receiver
// stalls, a long output hold and a paused sender.
// ----------------------------------------------------------------------------
module tb;

  localparam int CB            = tbc_pkg::COORD_BITS_DEF;
  localparam int PW            = 4 * CB;       // room for the full dot product
  localparam int SETTLE_CYCLES = tbc_pkg::N_STG + 4;
  localparam int LIMIT_CYCLES  = 400000;

  // Index with no register behind it
  localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;

  // Polygon flag bits
  localparam int FLG_ACTIVE    = 0;
  localparam int FLG_CLIPPED   = 1;
  localparam int FLG_TWO_SIDED = 2;
  localparam int FLG_BACKFACE  = 3;
  localparam logic [3:0] FLAGS_TESTED = 4'b0001;

  typedef logic signed [CB-1:0] coord_t;

  localparam coord_t CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam coord_t CMAX = {1'b0, {(CB-1){1'b1}}};

  typedef struct packed {
    logic [2:0][2:0][CB-1:0] vtx;   // [vertex][axis]
    logic [3:0]              flags;
    logic                    last;
  } triangle_t;

  typedef struct packed {
    logic backface;
    logic tested;
    logic last;
  } verdict_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [1:0]                   cfg_idx;
  logic [tbc_pkg::REG_BITS-1:0] cfg_wdata;

  tbc_in_if #(.COORD_BITS(CB)) tri_ch ();
  tbc_out_if                   res_ch ();

  coord_t   cam_q [3];
  verdict_t verdicts_q [$];
  int       err_cnt;
  int       rx_hold_cycles;
  int       burst_left;
  int       cycle_cnt;
  rx_mode_t rx_mode;
  bit       tx_paced;

  triangle_backface_cull_core #(.COORD_BITS(CB)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tri    (tri_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Verdict of one triangle under the current camera, exact to the sign
  function automatic verdict_t predict_cull(input triangle_t t);
    logic signed [PW-1:0] p0 [3];
    logic signed [PW-1:0] e1 [3];
    logic signed [PW-1:0] e2 [3];
    logic signed [PW-1:0] view [3];
    logic signed [PW-1:0] nrm [3];
    logic signed [PW-1:0] dot;
    verdict_t             r;
    int                   k;
    r.backface = t.flags[FLG_BACKFACE];
    r.tested   = 1'b0;
    r.last     = t.last;
    if (t.flags[FLG_ACTIVE] && !t.flags[FLG_CLIPPED] && !t.flags[FLG_TWO_SIDED] &&
        !t.flags[FLG_BACKFACE]) begin
      for (k = 0; k < 3; k++) begin
        p0[k]   = $signed(t.vtx[0][k]);
        e1[k]   = $signed(t.vtx[1][k]) - p0[k];
        e2[k]   = $signed(t.vtx[2][k]) - p0[k];
        view[k] = cam_q[k] - p0[k];
      end
      nrm[0] = e1[1] * e2[2] - e1[2] * e2[1];
      nrm[1] = e1[2] * e2[0] - e1[0] * e2[2];
      nrm[2] = e1[0] * e2[1] - e1[1] * e2[0];
      dot = nrm[0] * view[0] + nrm[1] * view[1] + nrm[2] * view[2];
      r.tested   = 1'b1;
      r.backface = (dot <= 0);
    end
    return r;
  endfunction

  function automatic triangle_t mk_triangle(input coord_t ax, ay, az, bx, by, bz,
                                            cx, cy, cz, input logic [3:0] fl,
                                            input logic lst);
    triangle_t t;
    t.vtx[0][0] = ax; t.vtx[0][1] = ay; t.vtx[0][2] = az;
    t.vtx[1][0] = bx; t.vtx[1][1] = by; t.vtx[1][2] = bz;
    t.vtx[2][0] = cx; t.vtx[2][1] = cy; t.vtx[2][2] = cz;
    t.flags = fl;
    t.last  = lst;
    return t;
  endfunction

  // Mix of extremes, small values near zero and full-range values
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return CMIN;
      1:       return CMAX;
      2, 3:    return coord_t'(int'($urandom_range(0, 16)) - 8);
      default: return coord_t'($urandom());
    endcase
  endfunction

  // Mostly testable polygons; now and then a degenerate one
  function automatic triangle_t rand_triangle();
    triangle_t t;
    int        j;
    int        k;
    for (j = 0; j < 3; j++)
      for (k = 0; k < 3; k++)
        t.vtx[j][k] = rand_coord();
    case ($urandom_range(0, 15))
      0: for (k = 0; k < 3; k++) t.vtx[2][k] = t.vtx[0][k];
      1: for (k = 0; k < 3; k++) t.vtx[2][k] = t.vtx[1][k];
      default: ;
    endcase
    t.flags = ($urandom_range(0, 9) < 7) ? FLAGS_TESTED : 4'($urandom());
    t.last  = ($urandom_range(0, 7) == 0);
    return t;
  endfunction

  // Offer one triangle, hold it until the transfer, then log its verdict
  task automatic send_triangle(input triangle_t t);
    int gap;
    if (tx_paced) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        repeat (gap) @(negedge clk) tri_ch.valid <= 1'b0;
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    @(negedge clk);
    tri_ch.valid      <= 1'b1;
    tri_ch.v0_x       <= t.vtx[0][0];
    tri_ch.v0_y       <= t.vtx[0][1];
    tri_ch.v0_z       <= t.vtx[0][2];
    tri_ch.v1_x       <= t.vtx[1][0];
    tri_ch.v1_y       <= t.vtx[1][1];
    tri_ch.v1_z       <= t.vtx[1][2];
    tri_ch.v2_x       <= t.vtx[2][0];
    tri_ch.v2_y       <= t.vtx[2][1];
    tri_ch.v2_z       <= t.vtx[2][2];
    tri_ch.poly_flags <= t.flags;
    tri_ch.last_poly  <= t.last;
    @(posedge clk);
    while (!tri_ch.ready) @(posedge clk);
    verdicts_q.push_back(predict_cull(t));
  endtask

  // Stop offering and wait until every verdict is back
  task automatic drain();
    @(negedge clk) tri_ch.valid <= 1'b0;
    while (verdicts_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input coord_t data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk) cfg_we <= 1'b0;
    if (idx <= tbc_pkg::CFG_CAM_Z)
      cam_q[idx] = data;
  endtask

  task automatic set_camera(input coord_t x, input coord_t y, input coord_t z);
    write_reg(tbc_pkg::CFG_CAM_X, x);
    write_reg(tbc_pkg::CFG_CAM_Y, y);
    write_reg(tbc_pkg::CFG_CAM_Z, z);
  endtask

  // Every flag combination on a front-facing triangle, camera from reset
  task automatic test_flag_passthrough();
    int f;
    for (f = 0; f < 16; f++)
      send_triangle(mk_triangle(0, 0, -10, 1, 0, -10, 0, 1, -10, 4'(f), (f % 3) == 0));
    drain();
  endtask

  // Winding, degenerate, in-plane camera and extreme coordinates
  task automatic test_geometry();
    set_camera(0, 0, 10);
    send_triangle(mk_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0, FLAGS_TESTED, 1'b0));
    send_triangle(mk_triangle(0, 0, 0, 0, 1, 0, 1, 0, 0, FLAGS_TESTED, 1'b0));
    send_triangle(mk_triangle(0, 0, 0, 3, 4, 5, 3, 4, 5, FLAGS_TESTED, 1'b0));
    send_triangle(mk_triangle(0, 0, 10, 1, 0, 10, 0, 1, 10, FLAGS_TESTED, 1'b0));
    send_triangle(mk_triangle(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN,
                              FLAGS_TESTED, 1'b0));
    send_triangle(mk_triangle(CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN,
                              FLAGS_TESTED, 1'b0));
    send_triangle(mk_triangle(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN,
                              FLAGS_TESTED, 1'b1));
    drain();
  endtask

  // A write to the spare index must leave the camera alone
  task automatic test_unused_index();
    write_reg(CFG_IDX_UNUSED, CMIN);
    send_triangle(mk_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0, FLAGS_TESTED, 1'b0));
    send_triangle(mk_triangle(0, 0, 0, 0, 1, 0, 1, 0, 0, FLAGS_TESTED, 1'b1));
    drain();
  endtask

  // Random triangles under extreme and random cameras, varied pacing
  task automatic test_camera_sweep();
    int p;
    int i;
    for (p = 0; p < 7; p++) begin
      case (p)
        0:       set_camera(CMIN, CMIN, CMIN);
        1:       set_camera(CMAX, CMAX, CMAX);
        2:       set_camera(CMIN, CMAX, 0);
        default: set_camera(rand_coord(), rand_coord(), rand_coord());
      endcase
      rx_mode  = rx_mode_t'(p % 3);
      tx_paced = (p % 2) == 1;
      for (i = 0; i < 130; i++)
        send_triangle(rand_triangle());
      drain();
    end
  endtask

  // Hold the output off long enough for the pipeline to fill and back up
  task automatic test_output_hold();
    int i;
    rx_mode        = RX_ALWAYS;
    tx_paced       = 1'b0;
    rx_hold_cycles = 80;
    for (i = 0; i < 40; i++)
      send_triangle(rand_triangle());
    drain();
  endtask

  // Pause the sender mid-stream until all verdicts are back
  task automatic test_sender_pause();
    int i;
    rx_mode  = RX_RANDOM;
    tx_paced = 1'b1;
    for (i = 0; i < 30; i++)
      send_triangle(rand_triangle());
    drain();
    for (i = 0; i < 30; i++)
      send_triangle(rand_triangle());
    drain();
  endtask

  // Result receiver: long hold first, else the selected stall pattern
  initial begin : rx_proc
    int rx_phase;
    rx_phase     = 0;
    res_ch.ready = 1'b0;
    forever @(negedge clk) begin
      rx_phase = (rx_phase + 1) % 7;
      if (rx_hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        case (rx_mode)
          RX_ALWAYS:   res_ch.ready <= 1'b1;
          RX_RANDOM:   res_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: res_ch.ready <= (rx_phase < 4);
          default:     res_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest outstanding verdict
  always @(posedge clk) begin : verdict_chk
    verdict_t exp_v;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (verdicts_q.size() == 0) begin
        $error("unexpected result: backface %0b tested %0b last_out %0b",
               res_ch.backface, res_ch.tested, res_ch.last_out);
        err_cnt++;
      end else begin
        exp_v = verdicts_q.pop_front();
        if (res_ch.backface !== exp_v.backface) begin
          $error("backface: expected %0b, got %0b", exp_v.backface, res_ch.backface);
          err_cnt++;
        end
        if (res_ch.tested !== exp_v.tested) begin
          $error("tested: expected %0b, got %0b", exp_v.tested, res_ch.tested);
          err_cnt++;
        end
        if (res_ch.last_out !== exp_v.last) begin
          $error("last_out: expected %0b, got %0b", exp_v.last, res_ch.last_out);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("triangle_backface_cull_core: mismatch");
    $finish;
  end

  initial begin : main_seq
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = tbc_pkg::CFG_CAM_X;
    cfg_wdata         = '0;
    tri_ch.valid      = 1'b0;
    tri_ch.v0_x       = '0;
    tri_ch.v0_y       = '0;
    tri_ch.v0_z       = '0;
    tri_ch.v1_x       = '0;
    tri_ch.v1_y       = '0;
    tri_ch.v1_z       = '0;
    tri_ch.v2_x       = '0;
    tri_ch.v2_y       = '0;
    tri_ch.v2_z       = '0;
    tri_ch.poly_flags = '0;
    tri_ch.last_poly  = 1'b0;
    cam_q[0]          = '0;
    cam_q[1]          = '0;
    cam_q[2]          = '0;
    err_cnt           = 0;
    rx_hold_cycles    = 0;
    burst_left        = 0;
    rx_mode           = RX_ALWAYS;
    tx_paced          = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_flag_passthrough();
    test_geometry();
    test_unused_index();
    test_camera_sweep();
    test_output_hold();
    test_sender_pause();

    if (err_cnt == 0)
      $display("triangle_backface_cull_core: match");
    else
      $display("triangle_backface_cull_core: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
sv/tbc_pkg.sv
sv/tbc_in_if.sv
sv/tbc_out_if.sv
sv/tbc_pipe_ctrl.sv
sv/tbc_mul.sv
sv/triangle_backface_cull_core.sv
tb/tb.sv
